// ===== design/kdcc_pkg.sv =====
// Shared types, constants and helpers of the keyword detection confirm/cooldown unit.
`timescale 1ns / 1ps
package kdcc_pkg;

	localparam int MAX_CLASSES     = 8;
	localparam int NUM_CLASSES_DEF = 8;
	localparam int NUM_LIMITS      = MAX_CLASSES - 1;
	localparam int CLASS_W         = 3;
	localparam int SCORE_W         = 8;
	localparam int HITS_W          = 8;
	localparam int FRAME_W         = 32;
	localparam int LIMIT_W         = 24;
	localparam int COOL_W          = 16;
	localparam int DATA_W          = 32;
	localparam int ADDR_W          = 5;

	localparam logic [HITS_W-1:0] HIT_MAX       = 8'hFF;
	localparam logic [HITS_W-1:0] CONFIRM_RESET = 8'd2;

	typedef logic [LIMIT_W-1:0] limit_t;
	typedef limit_t [NUM_LIMITS-1:0] limit_vec_t;

	// Reset values of the per-class limits: threshold in 23:16, cooldown in 15:0.
	localparam limit_vec_t LIMITS_RESET = '{
		{8'd98, 16'd18},	// class 7
		{8'd98, 16'd18},	// class 6
		{8'd96, 16'd20},	// class 5
		{8'd96, 16'd20},	// class 4
		{8'd94, 16'd16},	// class 3
		{8'd94, 16'd16},	// class 2
		{8'd96, 16'd20}		// class 1
	};

	typedef enum logic [2:0] {
		REG_CLASS1_LIMITS = 3'd0,
		REG_CLASS2_LIMITS = 3'd1,
		REG_CLASS3_LIMITS = 3'd2,
		REG_CLASS4_LIMITS = 3'd3,
		REG_CLASS5_LIMITS = 3'd4,
		REG_CLASS6_LIMITS = 3'd5,
		REG_CLASS7_LIMITS = 3'd6,
		REG_CONFIRM       = 3'd7
	} reg_idx_t;

	typedef logic [SCORE_W-1:0] score_t;
	typedef score_t [MAX_CLASSES-1:0] score_vec_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score_0;
		logic [SCORE_W-1:0] score_1;
		logic [SCORE_W-1:0] score_2;
		logic [SCORE_W-1:0] score_3;
		logic [SCORE_W-1:0] score_4;
		logic [SCORE_W-1:0] score_5;
		logic [SCORE_W-1:0] score_6;
		logic [SCORE_W-1:0] score_7;
	} in_t;

	typedef struct packed {
		logic               report;
		logic [CLASS_W-1:0] keyword;
		logic [SCORE_W-1:0] confidence;
		logic [FRAME_W-1:0] frame_number;
	} out_t;

	// What one class lane found for the current frame.
	typedef struct packed {
		logic pass;		// score reaches the class threshold
		logic cooling;	// class reported recently, report must be held back
	} lane_flags_t;

	function automatic score_vec_t scores_of(input in_t d);
		score_vec_t v;
		v[0] = d.score_0;
		v[1] = d.score_1;
		v[2] = d.score_2;
		v[3] = d.score_3;
		v[4] = d.score_4;
		v[5] = d.score_5;
		v[6] = d.score_6;
		v[7] = d.score_7;
		return v;
	endfunction

endpackage

// ===== design/kdcc_lane.sv =====
// One keyword class lane: threshold test, cooldown test and last report frame.
`timescale 1ns / 1ps
module kdcc_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [kdcc_pkg::SCORE_W-1:0]  score,
	input  kdcc_pkg::limit_t              limits,
	input  logic [kdcc_pkg::FRAME_W-1:0]  frame_next,
	input  logic                          report_wr,
	output kdcc_pkg::lane_flags_t         flags
);
	import kdcc_pkg::*;

	logic [FRAME_W-1:0] last_report_q;
	logic [FRAME_W-1:0] delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_report_q <= '0;
		end else if (report_wr) begin
			last_report_q <= frame_next;
		end
	end

	// A stored zero means the class has never been reported.
	assign delta         = frame_next - last_report_q;
	assign flags.pass    = score >= limits[LIMIT_W-1:COOL_W];
	assign flags.cooling = (last_report_q != '0) &&
		(delta <= {{(FRAME_W-COOL_W){1'b0}}, limits[COOL_W-1:0]});

endmodule

// ===== design/kdcc_merge.sv =====
// Merging stage: picks the winning class and the flags of its lane.
`timescale 1ns / 1ps
module kdcc_merge #(
	parameter int NUM_CLASSES = kdcc_pkg::NUM_CLASSES_DEF
) (
	input  kdcc_pkg::score_vec_t                      scores,
	input  kdcc_pkg::lane_flags_t [NUM_CLASSES-1:0]   flags,
	output logic [kdcc_pkg::CLASS_W-1:0]              win,
	output logic [kdcc_pkg::SCORE_W-1:0]              best,
	output kdcc_pkg::lane_flags_t                     win_flags
);
	import kdcc_pkg::*;

	// Strictly greater replaces the leader, so the lowest index wins a tie.
	always_comb begin
		win       = '0;
		best      = scores[0];
		win_flags = flags[0];
		for (int i = 1; i < NUM_CLASSES; i++) begin
			if (scores[i] > best) begin
				win       = CLASS_W'(i);
				best      = scores[i];
				win_flags = flags[i];
			end
		end
	end

endmodule

// ===== design/keyword_detection_confirm_cooldown_unit.sv =====
// Top level of the keyword detection unit with confirmation and report cooldown.
`timescale 1ns / 1ps
// The result of an accepted frame is registered in the output stage, or in the skid stage.
// Throughput: one frame per cycle while the skid stage is empty; the class lanes, argmax chain
// and pending-state update are combinational, and a skid stage lets requests keep flowing.
// Reset (arst_n low) clears the frame counter, pending candidate, per-class last report
// frames and both output stages, and restores every configuration register to its default.
module keyword_detection_confirm_cooldown_unit #(
	parameter int NUM_CLASSES = kdcc_pkg::NUM_CLASSES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  kdcc_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output kdcc_pkg::out_t               out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kdcc_pkg::ADDR_W-1:0]  paddr,
	input  logic [kdcc_pkg::DATA_W-1:0]  pwdata,
	output logic [kdcc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import kdcc_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers. Register n sits at byte address 4*n, so the
	// register index is simply the word address.
	// ------------------------------------------------------------------
	limit_vec_t          limits_q;
	logic [HITS_W-1:0]   confirm_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q  <= LIMITS_RESET;
			confirm_q <= CONFIRM_RESET;
		end else if (cfg_wr) begin
			if (reg_idx == REG_CONFIRM) begin
				confirm_q <= pwdata[HITS_W-1:0];
			end else begin
				limits_q[reg_idx] <= pwdata[LIMIT_W-1:0];
			end
		end
	end

	always_comb begin
		if (reg_idx == REG_CONFIRM) begin
			prdata = {{(DATA_W-HITS_W){1'b0}}, confirm_q};
		end else begin
			prdata = {{(DATA_W-LIMIT_W){1'b0}}, limits_q[reg_idx]};
		end
	end

	// ------------------------------------------------------------------
	// Request acceptance. A request is taken whenever the skid stage is
	// empty, so a result waiting in the output stage does not stall input.
	// ------------------------------------------------------------------
	logic               out_valid_q;
	logic               skid_valid_q;
	out_t               out_data_q;
	out_t               skid_data_q;
	logic               accept;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Frame state: counter and the pending candidate.
	// ------------------------------------------------------------------
	logic [FRAME_W-1:0] frame_counter_q;
	logic [CLASS_W-1:0] pending_class_q;
	logic [HITS_W-1:0]  pending_hits_q;
	logic [FRAME_W-1:0] pending_frame_q;
	logic [FRAME_W-1:0] frame_next;

	assign frame_next = frame_counter_q + 1'b1;

	// ------------------------------------------------------------------
	// Class lanes. Lane 0 is the unknown class: it never qualifies and
	// has no thresholds or cooldown, so its flags are tied off.
	// ------------------------------------------------------------------
	score_vec_t                            scores;
	lane_flags_t [NUM_CLASSES-1:0]         flags;
	logic [CLASS_W-1:0]                    win;
	logic [SCORE_W-1:0]                    best;
	lane_flags_t                           win_flags;
	logic                                  report;

	assign scores   = scores_of(in_data);
	assign flags[0] = '0;

	for (genvar g = 1; g < NUM_CLASSES; g++) begin : g_lane
		kdcc_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.score      (scores[g]),
			.limits     (limits_q[g-1]),
			.frame_next (frame_next),
			.report_wr  (accept && report && (win == CLASS_W'(g))),
			.flags      (flags[g])
		);
	end

	kdcc_merge #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_merge (
		.scores    (scores),
		.flags     (flags),
		.win       (win),
		.best      (best),
		.win_flags (win_flags)
	);

	// ------------------------------------------------------------------
	// Candidate update. The hit run continues only when the same class won
	// the immediately previous frame, i.e. the pending frame is the current
	// counter value before this frame's increment.
	// ------------------------------------------------------------------
	logic               qualified;
	logic               run_continues;
	logic [HITS_W-1:0]  hits_new;
	out_t               result;

	assign qualified     = (win != '0) && win_flags.pass;
	assign run_continues = (pending_class_q == win) && (pending_frame_q == frame_counter_q);

	always_comb begin
		if (!run_continues) begin
			hits_new = HITS_W'(1);
		end else if (pending_hits_q == HIT_MAX) begin
			hits_new = HIT_MAX;
		end else begin
			hits_new = pending_hits_q + 1'b1;
		end
	end

	// A confirm count of zero behaves as one, since the hit count is at least one here.
	assign report = qualified && (hits_new >= confirm_q) && !win_flags.cooling;

	assign result.report       = report;
	assign result.keyword      = win;
	assign result.confidence   = best;
	assign result.frame_number = frame_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_counter_q <= '0;
			pending_class_q <= '0;
			pending_hits_q  <= '0;
			pending_frame_q <= '0;
		end else if (accept) begin
			frame_counter_q <= frame_next;
			if (qualified) begin
				pending_class_q <= win;
				pending_hits_q  <= hits_new;
				pending_frame_q <= frame_next;
			end else begin
				pending_class_q <= '0;
				pending_hits_q  <= '0;
				pending_frame_q <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register with skid stage. The skid stage only fills when a
	// request is accepted while the output stage is held by the consumer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (accept) begin
				out_data_q <= result;
			end
		end else if (accept) begin
			skid_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
